// File: rtl/core/vctf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vctf_pkg;

    // Component kinds as they arrive on the input.
    typedef enum logic [2:0] {
        KIND_S8  = 3'd0,
        KIND_U8  = 3'd1,
        KIND_S16 = 3'd2,
        KIND_U16 = 3'd3,
        KIND_S32 = 3'd4,
        KIND_U32 = 3'd5,
        KIND_F32 = 3'd6,
        KIND_F64 = 3'd7
    } kind_t;

    // Which datapath produces the result of an item.
    typedef enum logic [1:0] {
        PATH_CONST = 2'd0,
        PATH_INT   = 2'd1,
        PATH_DBL   = 2'd2,
        PATH_FRAC  = 2'd3
    } path_t;

    // Block width of a normalised fraction: the divisor is 2^n - 1.
    typedef enum logic [1:0] {
        FRAC_W7  = 2'd0,
        FRAC_W8  = 2'd1,
        FRAC_W15 = 2'd2,
        FRAC_W16 = 2'd3
    } frac_w_t;

    localparam logic [31:0] FP_ZERO    = 32'h0000_0000;
    localparam logic [31:0] FP_POS_ONE = 32'h3F80_0000;
    localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
    localparam logic [7:0]  EXP_MAX    = 8'hFF;
    localparam logic [12:0] DBL_TO_SGL_BIAS = 13'd896;
    localparam logic [7:0]  INT_EXP_TOP  = 8'd158;
    localparam logic [7:0]  FRAC_EXP_TOP = 8'd126;
    localparam logic [7:0]  U32_SCALE    = 8'd32;

    // Decoded item after the first stage.
    typedef struct packed {
        path_t          path;
        logic [31:0]    const_bits;
        logic           sign;
        logic [31:0]    int_mag;
        logic           int_scale;
        logic [52:0]    dbl_sig;
        logic [5:0]     dbl_shift;
        logic [7:0]     dbl_exp;
        logic [15:0]    frac_mag;
        frac_w_t        frac_w;
    } dec_t;

    // Aligned significand ready for rounding.
    typedef struct packed {
        logic           is_const;
        logic [31:0]    const_bits;
        logic           sign;
        logic [7:0]     exp;
        logic [22:0]    mant;
        logic           rnd;
        logic           stk;
    } aln_t;

endpackage

`default_nettype wire

// File: rtl/core/vctf_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module vctf_decode (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [63:0]    raw_bits,
    input  wire logic [2:0]     component_kind,
    input  wire logic           is_normalized,
    output logic                out_valid,
    input  wire logic           out_ready,
    output vctf_pkg::dec_t      out_data
);
    import vctf_pkg::*;

    logic           valid_reg;
    logic           valid_next;
    dec_t           data_reg;
    dec_t           data_next;
    kind_t          kind;
    logic [10:0]    dexp;
    logic signed [12:0] fexp;
    logic [7:0]     mag8;
    logic [15:0]    mag16;
    logic [31:0]    mag32;

    assign kind  = kind_t'(component_kind);
    assign dexp  = raw_bits[62:52];
    assign fexp  = $signed({2'b00, dexp} - DBL_TO_SGL_BIAS);
    assign mag8  = raw_bits[7]  ? (~raw_bits[7:0]  + 8'd1)  : raw_bits[7:0];
    assign mag16 = raw_bits[15] ? (~raw_bits[15:0] + 16'd1) : raw_bits[15:0];
    assign mag32 = raw_bits[31] ? (~raw_bits[31:0] + 32'd1) : raw_bits[31:0];

    always_comb begin
        data_next            = '0;
        data_next.path       = PATH_CONST;
        data_next.const_bits = FP_ZERO;
        data_next.frac_w     = FRAC_W7;
        if (is_normalized) begin
            unique case (kind)
                KIND_S8: begin
                    if (raw_bits[7:0] == 8'h00) begin
                        data_next.const_bits = FP_ZERO;
                    end else if (raw_bits[7:0] == 8'h80 || raw_bits[7:0] == 8'h81) begin
                        data_next.const_bits = FP_NEG_ONE;
                    end else if (raw_bits[7:0] == 8'h7F) begin
                        data_next.const_bits = FP_POS_ONE;
                    end else begin
                        data_next.path     = PATH_FRAC;
                        data_next.sign     = raw_bits[7];
                        data_next.frac_mag = {8'h00, mag8};
                        data_next.frac_w   = FRAC_W7;
                    end
                end
                KIND_U8: begin
                    if (raw_bits[7:0] == 8'h00) begin
                        data_next.const_bits = FP_ZERO;
                    end else if (raw_bits[7:0] == 8'hFF) begin
                        data_next.const_bits = FP_POS_ONE;
                    end else begin
                        data_next.path     = PATH_FRAC;
                        data_next.frac_mag = {8'h00, raw_bits[7:0]};
                        data_next.frac_w   = FRAC_W8;
                    end
                end
                KIND_S16: begin
                    if (raw_bits[15:0] == 16'h0000) begin
                        data_next.const_bits = FP_ZERO;
                    end else if (raw_bits[15:0] == 16'h8000 || raw_bits[15:0] == 16'h8001) begin
                        data_next.const_bits = FP_NEG_ONE;
                    end else if (raw_bits[15:0] == 16'h7FFF) begin
                        data_next.const_bits = FP_POS_ONE;
                    end else begin
                        data_next.path     = PATH_FRAC;
                        data_next.sign     = raw_bits[15];
                        data_next.frac_mag = mag16;
                        data_next.frac_w   = FRAC_W15;
                    end
                end
                KIND_U16: begin
                    if (raw_bits[15:0] == 16'h0000) begin
                        data_next.const_bits = FP_ZERO;
                    end else if (raw_bits[15:0] == 16'hFFFF) begin
                        data_next.const_bits = FP_POS_ONE;
                    end else begin
                        data_next.path     = PATH_FRAC;
                        data_next.frac_mag = raw_bits[15:0];
                        data_next.frac_w   = FRAC_W16;
                    end
                end
                KIND_U32: begin
                    data_next.path      = PATH_INT;
                    data_next.int_mag   = raw_bits[31:0];
                    data_next.int_scale = 1'b1;
                end
                default: begin
                    data_next.const_bits = FP_ZERO;
                end
            endcase
        end else begin
            unique case (kind)
                KIND_S8: begin
                    data_next.path    = PATH_INT;
                    data_next.sign    = raw_bits[7];
                    data_next.int_mag = {24'h0, mag8};
                end
                KIND_U8: begin
                    data_next.path    = PATH_INT;
                    data_next.int_mag = {24'h0, raw_bits[7:0]};
                end
                KIND_S16: begin
                    data_next.path    = PATH_INT;
                    data_next.sign    = raw_bits[15];
                    data_next.int_mag = {16'h0, mag16};
                end
                KIND_U16: begin
                    data_next.path    = PATH_INT;
                    data_next.int_mag = {16'h0, raw_bits[15:0]};
                end
                KIND_S32: begin
                    data_next.path    = PATH_INT;
                    data_next.sign    = raw_bits[31];
                    data_next.int_mag = mag32;
                end
                KIND_U32: begin
                    data_next.path    = PATH_INT;
                    data_next.int_mag = raw_bits[31:0];
                end
                KIND_F32: begin
                    data_next.const_bits = raw_bits[31:0];
                end
                KIND_F64: begin
                    data_next.sign = raw_bits[63];
                    if (dexp == 11'h7FF) begin
                        if (raw_bits[51:0] != 52'h0) begin
                            data_next.const_bits = {raw_bits[63], EXP_MAX, 1'b1, raw_bits[51:30]};
                        end else begin
                            data_next.const_bits = {raw_bits[63], EXP_MAX, 23'h0};
                        end
                    end else if (dexp == 11'h000) begin
                        data_next.const_bits = {raw_bits[63], 31'h0};
                    end else if (fexp >= 13'sd255) begin
                        data_next.const_bits = {raw_bits[63], EXP_MAX, 23'h0};
                    end else begin
                        data_next.path    = PATH_DBL;
                        data_next.dbl_sig = {1'b1, raw_bits[51:0]};
                        if (fexp >= 13'sd1) begin
                            data_next.dbl_shift = 6'd29;
                            data_next.dbl_exp   = fexp[7:0];
                        end else if (fexp < -13'sd33) begin
                            data_next.dbl_shift = 6'd63;
                        end else begin
                            data_next.dbl_shift = 6'(13'sd30 - fexp);
                        end
                    end
                end
                default: begin
                    data_next.const_bits = FP_ZERO;
                end
            endcase
        end
        // A zero integer has no leading one to find.
        if (data_next.path == PATH_INT && data_next.int_mag == 32'h0) begin
            data_next.path       = PATH_CONST;
            data_next.const_bits = FP_ZERO;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/core/vctf_align.sv
`timescale 1ns / 1ps
`default_nettype none

module vctf_align (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire vctf_pkg::dec_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output vctf_pkg::aln_t      out_data
);
    import vctf_pkg::*;

    logic           valid_reg;
    logic           valid_next;
    aln_t           data_reg;
    aln_t           data_next;
    logic [4:0]     int_lz;
    logic [31:0]    int_norm;
    logic [116:0]   dbl_wide;
    logic [15:0]    frac_left;
    logic [3:0]     frac_lz;
    logic [47:0]    frac_pat;
    logic [47:0]    frac_norm;
    logic [104:0]   rep7;
    logic [59:0]    rep15;

    // Leading zeros of the integer magnitude; the magnitude is never zero here.
    always_comb begin
        int_lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (in_data.int_mag[i]) begin
                int_lz = 5'(31 - i);
            end
        end
    end

    assign int_norm = in_data.int_mag << int_lz;
    assign dbl_wide = {in_data.dbl_sig, 64'h0} >> in_data.dbl_shift;

    // A quotient x / (2^n - 1) with 0 < x < 2^n - 1 is the n-bit block of x
    // repeated without end, so its bits are known exactly and never tie.
    always_comb begin
        rep7  = {15{in_data.frac_mag[6:0]}};
        rep15 = {4{in_data.frac_mag[14:0]}};
        unique case (in_data.frac_w)
            FRAC_W7: begin
                frac_left = {in_data.frac_mag[6:0], 9'h0};
                frac_pat  = rep7[104:57];
            end
            FRAC_W8: begin
                frac_left = {in_data.frac_mag[7:0], 8'h0};
                frac_pat  = {6{in_data.frac_mag[7:0]}};
            end
            FRAC_W15: begin
                frac_left = {in_data.frac_mag[14:0], 1'b0};
                frac_pat  = rep15[59:12];
            end
            FRAC_W16: begin
                frac_left = in_data.frac_mag;
                frac_pat  = {3{in_data.frac_mag}};
            end
            default: begin
                frac_left = in_data.frac_mag;
                frac_pat  = {3{in_data.frac_mag}};
            end
        endcase
    end

    always_comb begin
        frac_lz = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (frac_left[i]) begin
                frac_lz = 4'(15 - i);
            end
        end
    end

    assign frac_norm = frac_pat << frac_lz;

    always_comb begin
        data_next            = '0;
        data_next.sign       = in_data.sign;
        data_next.const_bits = in_data.const_bits;
        unique case (in_data.path)
            PATH_CONST: begin
                data_next.is_const = 1'b1;
            end
            PATH_INT: begin
                data_next.exp  = (INT_EXP_TOP - {3'b000, int_lz})
                               - (in_data.int_scale ? U32_SCALE : 8'd0);
                data_next.mant = int_norm[30:8];
                data_next.rnd  = int_norm[7];
                data_next.stk  = |int_norm[6:0];
            end
            PATH_DBL: begin
                data_next.exp  = in_data.dbl_exp;
                data_next.mant = dbl_wide[86:64];
                data_next.rnd  = dbl_wide[63];
                data_next.stk  = |dbl_wide[62:0];
            end
            PATH_FRAC: begin
                data_next.exp  = FRAC_EXP_TOP - {4'b0000, frac_lz};
                data_next.mant = frac_norm[46:24];
                data_next.rnd  = frac_norm[23];
                data_next.stk  = 1'b1;
            end
            default: begin
                data_next.is_const = 1'b1;
            end
        endcase
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/core/vctf_round.sv
`timescale 1ns / 1ps
`default_nettype none

module vctf_round (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire vctf_pkg::aln_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [31:0]         out_bits
);
    import vctf_pkg::*;

    logic           valid_reg;
    logic           valid_next;
    logic [31:0]    bits_reg;
    logic [31:0]    bits_next;
    logic           round_up;
    logic [30:0]    field;

    // Round to nearest even; a carry out of the mantissa bumps the exponent.
    assign round_up  = in_data.rnd && (in_data.stk || in_data.mant[0]);
    assign field     = {in_data.exp, in_data.mant} + {30'h0, round_up};
    assign bits_next = in_data.is_const ? in_data.const_bits : {in_data.sign, field};

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            bits_reg <= bits_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bits  = bits_reg;

endmodule

`default_nettype wire

// File: rtl/core/vertex_component_to_float_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts one vertex-attribute component (raw little-endian bits, kind and
// normalised flag) to an IEEE single-precision bit pattern. The block is a
// three-stage pipeline: decode, alignment (leading-one search and shift) and
// rounding, with the rounding register serving as the output register. It
// takes one item in every clock cycle while the output side is not stalled,
// and each result passes the decode, alignment and rounding registers in turn;
// input ready falls only when all three stages hold items that cannot move on.
// Normalised 8 and 16-bit kinds are divided by 2^n - 1 exactly, using the
// repeating binary expansion of such quotients, so no divider is present.
// The block holds no state besides the pipeline, and reset empties it.
module vertex_component_to_float_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [63:0]    s_raw_bits,
    input  wire logic [2:0]     s_component_kind,
    input  wire logic           s_is_normalized,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [31:0]         m_result_float
);
    import vctf_pkg::*;

    logic   dec_valid;
    logic   dec_ready;
    dec_t   dec_data;
    logic   aln_valid;
    logic   aln_ready;
    aln_t   aln_data;

    // First stage: pick the datapath and pull out magnitudes and exponents.
    vctf_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .raw_bits       (s_raw_bits),
        .component_kind (s_component_kind),
        .is_normalized  (s_is_normalized),
        .out_valid      (dec_valid),
        .out_ready      (dec_ready),
        .out_data       (dec_data)
    );

    // Second stage: normalise the significand and split off round and sticky.
    vctf_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (aln_valid),
        .out_ready (aln_ready),
        .out_data  (aln_data)
    );

    // Third stage: round to nearest even and hold the result for the consumer.
    vctf_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (aln_valid),
        .in_ready  (aln_ready),
        .in_data   (aln_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_bits  (m_result_float)
    );

`ifndef SYNTHESIS
    // An accepted item always lands in the decode stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> dec_valid)
        else $error("accepted item missing from decode stage");

    // A stalled aligned item holds its value until the rounding stage takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        aln_valid && !aln_ready |=> aln_valid && $stable(aln_data))
        else $error("aligned item lost or changed during stall");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !dec_valid && !aln_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
